/* hw/rtl/mdio_pkg.sv */
// shared types and constants for the mdio management master
package mdio_pkg;

   localparam int PREAMBLE_BITS = 32;
   localparam int DIVIDER_WIDTH = 8;
   localparam int FRAME_BITS    = 64;
   localparam int TAIL_BITS     = 32;
   localparam int IDX_W         = 7;
   localparam int DATA_W        = 16;

   // bit positions within a frame, counted in finished bits
   localparam logic [IDX_W-1:0] RELEASE_IDX = IDX_W'(PREAMBLE_BITS + 14);
   localparam logic [IDX_W-1:0] TA_IDX      = IDX_W'(PREAMBLE_BITS + 15);
   localparam logic [IDX_W-1:0] DATA_IDX    = IDX_W'(PREAMBLE_BITS + 16);
   localparam logic [IDX_W-1:0] END_IDX     = IDX_W'(PREAMBLE_BITS + 32);

   // operation codes on the request channel
   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_CMD_WRITE = 2'd1;

   // configuration register indexes
   localparam logic [1:0] REG_CLAUSE_22    = 2'd0;
   localparam logic [1:0] REG_HALF_PERIOD  = 2'd1;
   localparam logic [1:0] REG_FREE_RUNNING = 2'd2;

   localparam logic [1:0] TA_WRITE = 2'b10;

   typedef struct packed {
      logic                     clause_22;
      logic [DIVIDER_WIDTH-1:0] half_period;
      logic                     free_running;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic              start_req;
      logic [1:0]        opcode;
      logic [4:0]        port_address;
      logic [4:0]        device_address;
      logic [DATA_W-1:0] command_data;
      logic              mdio_in;
   } cmd_type;

   typedef struct packed {
      logic              busy_res;
      logic              fail;
      logic [DATA_W-1:0] read_data;
      logic              mdc;
      logic              mdio_out;
      logic              mdio_drive;
   } rsp_type;

endpackage

/* hw/rtl/mdio_master_controller.sv */
// mdio management master: clause 22 and clause 45 frames
// results: each accepted request beat registers its result beat into the result buffer
// throughput: one request beat per cycle; a two-beat result buffer keeps taking
//   requests while up to one earlier result is still waiting on rsp_tready
// reset: synchronous; idle, mdc low, data register and fail cleared,
//   clause_22 = 1, half_period = 12, free_running = 0
module mdio_master_controller import mdio_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] start_req, [2:1] opcode, [7:3] port_address, [12:8] device_address,
   // [28:13] command_data, [29] mdio_in, [31:30] zero
   input  logic [31:0] req_tdata,
   // [1:0] operation
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] busy_res, [1] fail, [17:2] read_data, [18] mdc, [19] mdio_out,
   // [20] mdio_drive, [23:21] zero
   output logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   rsp_type    eng_rsp, out_rsp;
   logic       accept, full;
   logic       csr_write;
   logic [1:0] reg_idx;

   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_CLAUSE_22:    cfg_in.clause_22    = csr_pwdata[0];
            REG_HALF_PERIOD:  cfg_in.half_period  = csr_pwdata[DIVIDER_WIDTH-1:0];
            REG_FREE_RUNNING: cfg_in.free_running = csr_pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clause_22    <= 1'b1;
         cfg_ff.half_period  <= DIVIDER_WIDTH'(12);
         cfg_ff.free_running <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CLAUSE_22:    csr_prdata = {31'd0, cfg_ff.clause_22};
         REG_HALF_PERIOD:  csr_prdata = 32'(cfg_ff.half_period);
         REG_FREE_RUNNING: csr_prdata = {31'd0, cfg_ff.free_running};
         default:          csr_prdata = '0;
      endcase
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd.operation      = req_tuser;
      cmd.start_req      = req_tdata[0];
      cmd.opcode         = req_tdata[2:1];
      cmd.port_address   = req_tdata[7:3];
      cmd.device_address = req_tdata[12:8];
      cmd.command_data   = req_tdata[28:13];
      cmd.mdio_in        = req_tdata[29];
   end

   mdio_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (accept),
      .cmd       (cmd),
      .rsp       (eng_rsp)
   );

   mdio_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (eng_rsp),
      .full      (full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   assign rsp_tdata = {3'd0, out_rsp.mdio_drive, out_rsp.mdio_out, out_rsp.mdc,
                       out_rsp.read_data, out_rsp.fail, out_rsp.busy_res};

`ifndef NO_ASSERTIONS
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request beat produced no result beat");

   a_released_low: assert property (@(posedge clock) disable iff (reset)
      accept && !eng_rsp.mdio_drive |-> !eng_rsp.mdio_out)
      else $error("data pin value set while released");

   a_full_means_pending: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no result pending");
`endif

endmodule

/* hw/rtl/mdio_engine.sv */
// frame engine: divider, management clock, frame shifter and read capture
module mdio_engine import mdio_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output rsp_type rsp
);

   logic                     busy_ff, busy_in;
   logic                     fail_ff, fail_in;
   logic                     read_ff, read_in;
   logic                     level_ff, level_in;
   logic [FRAME_BITS-1:0]    shift_ff, shift_in;
   logic [IDX_W-1:0]         idx_ff, idx_in, idx_next;
   logic [DIVIDER_WIDTH-1:0] count_ff, count_in, div_eff;
   logic [DIVIDER_WIDTH:0]   count_sum;
   logic [DATA_W-1:0]        data_ff, data_in;
   logic [TAIL_BITS-1:0]     tail;
   logic [FRAME_BITS-1:0]    pre_ones;
   logic                     drive;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         fail_ff  <= 1'b0;
         read_ff  <= 1'b0;
         level_ff <= 1'b0;
         shift_ff <= '0;
         idx_ff   <= '0;
         count_ff <= '0;
         data_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         fail_ff  <= fail_in;
         read_ff  <= read_in;
         level_ff <= level_in;
         shift_ff <= shift_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         data_ff  <= data_in;
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      fail_in   = fail_ff;
      read_in   = read_ff;
      level_in  = level_ff;
      shift_in  = shift_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      data_in   = data_ff;
      idx_next  = idx_ff + IDX_W'(1);
      div_eff   = (cfg.half_period == '0) ? DIVIDER_WIDTH'(1) : cfg.half_period;
      count_sum = {1'b0, count_ff} + (DIVIDER_WIDTH+1)'(1);
      pre_ones  = (FRAME_BITS'(1) << PREAMBLE_BITS) - FRAME_BITS'(1);

      // start code is 01 for clause 22, 00 for clause 45
      tail = {1'b0, cfg.clause_22, cmd.opcode, cmd.port_address, cmd.device_address,
              TA_WRITE, cmd.command_data};
      if (cmd.opcode[1]) begin
         tail[17:0] = '0;
      end

      if (cmd_valid) begin
         if (cmd.operation == OP_TICK) begin
            if (!busy_ff && !cfg.free_running) begin
               level_in = 1'b0;
               count_in = '0;
            end else if (count_sum < {1'b0, div_eff}) begin
               count_in = count_sum[DIVIDER_WIDTH-1:0];
            end else begin
               count_in = '0;
               level_in = !level_ff;
               if (!level_ff) begin
                  // rising edge: sample the phy in read frames
                  if (busy_ff && read_ff) begin
                     if (idx_ff == TA_IDX) begin
                        fail_in = cmd.mdio_in;
                     end else if (idx_ff >= DATA_IDX && idx_ff < END_IDX) begin
                        data_in = {data_ff[DATA_W-2:0], cmd.mdio_in};
                     end
                  end
               end else if (busy_ff) begin
                  // falling edge: next frame bit
                  if (idx_next >= END_IDX) begin
                     busy_in  = 1'b0;
                     read_in  = 1'b0;
                     idx_in   = '0;
                     shift_in = '0;
                  end else begin
                     idx_in   = idx_next;
                     shift_in = {shift_ff[FRAME_BITS-2:0], 1'b0};
                  end
               end
            end
         end else if (cmd.operation == OP_CMD_WRITE && !busy_ff) begin
            data_in = cmd.command_data;
            if (cmd.start_req) begin
               read_in  = cmd.opcode[1];
               shift_in = ((pre_ones << TAIL_BITS) | {{(FRAME_BITS-TAIL_BITS){1'b0}}, tail})
                          << (TAIL_BITS - PREAMBLE_BITS);
               idx_in   = '0;
               busy_in  = 1'b1;
               fail_in  = 1'b0;
               level_in = 1'b0;
               count_in = '0;
            end
         end
      end

      drive = busy_in && !(read_in && idx_in >= RELEASE_IDX);

      rsp.busy_res   = busy_in;
      rsp.fail       = fail_in;
      rsp.read_data  = data_in;
      rsp.mdc        = level_in;
      rsp.mdio_out   = drive & shift_in[FRAME_BITS-1];
      rsp.mdio_drive = drive;
   end

endmodule

/* hw/rtl/mdio_skid.sv */
// two-entry result buffer between the engine and the response channel
module mdio_skid import mdio_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   always_comb begin
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];

endmodule

/* bench/mdio_frame_checker.sv */
// watches the mdio master's channels, predicts each status beat and compares it
module mdio_frame_checker import mdio_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type                  cfg_q;
   logic                     busy_q;
   logic                     fail_q;
   logic                     read_q;
   logic                     level_q;
   logic [FRAME_BITS-1:0]    shift_q;
   logic [IDX_W-1:0]         idx_q;
   logic [DIVIDER_WIDTH-1:0] count_q;
   logic [DATA_W-1:0]        data_q;
   rsp_type                  expected_status[$];

   function automatic rsp_type unpack_status(logic [23:0] d);
      rsp_type s;
      s.busy_res   = d[0];
      s.fail       = d[1];
      s.read_data  = d[17:2];
      s.mdc        = d[18];
      s.mdio_out   = d[19];
      s.mdio_drive = d[20];
      return s;
   endfunction

   function automatic string show_status(rsp_type s);
      return $sformatf("busy=%0d fail=%0d data=%h mdc=%0d out=%0d drive=%0d",
                       s.busy_res, s.fail, s.read_data, s.mdc, s.mdio_out, s.mdio_drive);
   endfunction

   function automatic rsp_type line_status();
      rsp_type s;
      logic    drive;
      // read frames let go of the line once the device address is out
      drive        = busy_q && !(read_q && idx_q >= RELEASE_IDX);
      s.busy_res   = busy_q;
      s.fail       = fail_q;
      s.read_data  = data_q;
      s.mdc        = level_q;
      s.mdio_out   = drive & shift_q[FRAME_BITS-1];
      s.mdio_drive = drive;
      return s;
   endfunction

   task automatic report(string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic launch_frame(logic [1:0] opc, logic [4:0] port, logic [4:0] dev,
                               logic [15:0] wdata);
      logic [FRAME_BITS-1:0] pre;
      logic [TAIL_BITS-1:0]  tail;
      pre  = (64'd1 << PREAMBLE_BITS) - 64'd1;
      tail = {1'b0, cfg_q.clause_22, opc, port, dev, 2'b00, 16'h0000};
      read_q = opc[1];
      if (!read_q)
         tail[17:0] = {TA_WRITE, wdata};
      shift_q = ((pre << TAIL_BITS) | FRAME_BITS'(tail)) << (TAIL_BITS - PREAMBLE_BITS);
      idx_q   = '0;
      busy_q  = 1'b1;
      fail_q  = 1'b0;
      level_q = 1'b0;
      count_q = '0;
   endtask

   task automatic clock_tick(logic pin);
      logic [DIVIDER_WIDTH-1:0] half;
      half = (cfg_q.half_period == '0) ? DIVIDER_WIDTH'(1) : cfg_q.half_period;
      if (!busy_q && !cfg_q.free_running) begin
         level_q = 1'b0;
         count_q = '0;
      end else begin
         count_q = count_q + 1'b1;
         if (count_q >= half) begin
            count_q = '0;
            level_q = ~level_q;
            if (level_q) begin
               // rising edge: sample the phy in read frames
               if (busy_q && read_q) begin
                  if (idx_q == TA_IDX)
                     fail_q = pin;
                  else if (idx_q >= DATA_IDX && idx_q < END_IDX)
                     data_q = {data_q[DATA_W-2:0], pin};
               end
            end else if (busy_q) begin
               shift_q = shift_q << 1;
               idx_q   = idx_q + 1'b1;
               if (idx_q >= END_IDX) begin
                  busy_q  = 1'b0;
                  read_q  = 1'b0;
                  idx_q   = '0;
                  shift_q = '0;
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type     got;
      rsp_type     want;
      logic [31:0] reg_value;
      if (reset) begin
         cfg_q.clause_22    = 1'b1;
         cfg_q.half_period  = DIVIDER_WIDTH'(12);
         cfg_q.free_running = 1'b0;
         busy_q  = 1'b0;
         fail_q  = 1'b0;
         read_q  = 1'b0;
         level_q = 1'b0;
         shift_q = '0;
         idx_q   = '0;
         count_q = '0;
         data_q  = '0;
         expected_status.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            case (csr_paddr[3:2])
               REG_CLAUSE_22:    reg_value = {31'b0, cfg_q.clause_22};
               REG_HALF_PERIOD:  reg_value = {{(32-DIVIDER_WIDTH){1'b0}}, cfg_q.half_period};
               REG_FREE_RUNNING: reg_value = {31'b0, cfg_q.free_running};
               default:          reg_value = '0;
            endcase
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  REG_CLAUSE_22:    cfg_q.clause_22    = csr_pwdata[0];
                  REG_HALF_PERIOD:  cfg_q.half_period  = csr_pwdata[DIVIDER_WIDTH-1:0];
                  REG_FREE_RUNNING: cfg_q.free_running = csr_pwdata[0];
                  default: ;
               endcase
            end else if (csr_prdata !== reg_value) begin
               report($sformatf("register read at %h: expected %h got %h",
                                csr_paddr, reg_value, csr_prdata));
            end
         end

         // pop before push: a status beat never answers a request of the same edge
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_status(rsp_tdata);
            if (expected_status.size() == 0) begin
               report($sformatf("status beat with nothing pending: %s", show_status(got)));
            end else begin
               want = expected_status.pop_front();
               if (got !== want)
                  report($sformatf("expected %s, got %s", show_status(want), show_status(got)));
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_TICK) begin
               clock_tick(req_tdata[29]);
            end else if (req_tuser == OP_CMD_WRITE && !busy_q) begin
               data_q = req_tdata[28:13];
               if (req_tdata[0])
                  launch_frame(req_tdata[2:1], req_tdata[7:3], req_tdata[12:8],
                               req_tdata[28:13]);
            end
            expected_status.push_back(line_status());
         end
      end
      outstanding <= expected_status.size();
   end

endmodule

/* bench/testbench.sv */
// stimulus and verdict for the mdio master: frames, ticks, noise and register phases
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mdio_pkg::*;

   localparam logic [1:0] OP_CMD_READ = 2'd2;
   localparam logic [1:0] OP_SPARE    = 2'd3;
   localparam int RANDOM_ITEMS = 1300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [0] start_req, [2:1] opcode, [7:3] port_address, [12:8] device_address,
   // [28:13] command_data, [29] mdio_in, [31:30] zero
   logic [31:0] req_tdata;
   // [1:0] operation
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] busy_res, [1] fail, [17:2] read_data, [18] mdc, [19] mdio_out,
   // [20] mdio_drive, [23:21] zero
   logic [23:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int outstanding;
   int beats_sent = 0;
   int burst_left = 0;
   int stall_left = 0;
   int stall_mode = 0;
   int half_ticks = 12;

   mdio_master_controller DUT (.*);

   mdio_frame_checker frame_check (.*);

   always #6 clock = ~clock;

   // receiver: runs of always-ready, coin-flip, sparse and one-in-eight readiness
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(8, 64);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_left % 8 == 0);
      endcase
   end

   function automatic logic [31:0] pack_cmd(logic start, logic [1:0] opc, logic [4:0] port,
                                            logic [4:0] dev, logic [15:0] wdata, logic pin);
      return {2'b00, pin, wdata, dev, port, opc, start};
   endfunction

   function automatic logic [31:0] random_payload();
      return {2'b00, 30'($urandom)};
   endfunction

   function automatic logic [31:0] tick_payload(logic pin);
      logic [31:0] d;
      d     = random_payload();
      d[29] = pin;
      return d;
   endfunction

   task automatic send_beat(logic [1:0] op, logic [31:0] data);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_access(logic write, logic [1:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic c22, logic [7:0] div, logic free);
      wait_drained();
      csr_access(1'b1, REG_CLAUSE_22, {31'b0, c22});
      csr_access(1'b1, REG_HALF_PERIOD, {24'b0, div});
      csr_access(1'b1, REG_FREE_RUNNING, {31'b0, free});
      csr_access(1'b0, REG_CLAUSE_22, '0);
      csr_access(1'b0, REG_HALF_PERIOD, '0);
      csr_access(1'b0, REG_FREE_RUNNING, '0);
      half_ticks = (div == 0) ? 1 : div;
   endtask

   // pin_mode 0 or 1 holds the phy line, anything else randomizes it per tick
   task automatic run_frame(logic [31:0] cmd, int ticks, int noise_pct, int pin_mode);
      logic pin;
      send_beat(OP_CMD_WRITE, cmd);
      for (int i = 0; i < ticks; i++) begin
         pin = (pin_mode == 0 || pin_mode == 1) ? 1'(pin_mode) : 1'($urandom_range(0, 1));
         if ($urandom_range(0, 99) < noise_pct)
            send_beat(2'($urandom_range(1, 3)), random_payload());
         else
            send_beat(OP_TICK, tick_payload(pin));
      end
   endtask

   initial begin
      int          random_start;
      int          ticks;
      logic [7:0]  div;
      int          sel;
      logic [31:0] cmd;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_TICK;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: reads and the spare code do nothing, idle ticks keep mdc low
      send_beat(OP_CMD_READ, 32'h0000_0000);
      send_beat(OP_SPARE, 32'h3fff_ffff);
      send_beat(OP_TICK, tick_payload(1'b1));
      send_beat(OP_TICK, tick_payload(1'b0));
      // idle command write loads the data field without starting a frame
      send_beat(OP_CMD_WRITE, pack_cmd(1'b0, 2'd3, 5'h1f, 5'h1f, 16'hffff, 1'b1));
      send_beat(OP_CMD_WRITE, pack_cmd(1'b0, 2'd0, 5'h00, 5'h00, 16'h0000, 1'b0));

      // clause 45, zero divider, free running mdc while idle
      configure(1'b0, 8'h00, 1'b1);
      repeat (4) send_beat(OP_TICK, tick_payload(1'b0));
      // clause 45 read with the phy answering ones: fail set, data all ones;
      // a second command during the frame must be dropped
      send_beat(OP_CMD_WRITE, pack_cmd(1'b1, 2'd3, 5'h1f, 5'h1f, 16'hffff, 1'b1));
      send_beat(OP_CMD_WRITE, pack_cmd(1'b1, 2'd1, 5'h00, 5'h00, 16'h1234, 1'b0));
      send_beat(OP_CMD_READ, random_payload());
      repeat (128 * half_ticks) send_beat(OP_TICK, tick_payload(1'b1));

      // clause 22 write frames of both low opcodes, then a read the phy answers with zeros
      configure(1'b1, 8'h01, 1'b0);
      run_frame(pack_cmd(1'b1, 2'd1, 5'h00, 5'h00, 16'hffff, 1'b0), 128 * half_ticks + 2, 0, 0);
      run_frame(pack_cmd(1'b1, 2'd0, 5'h15, 5'h0a, 16'h5a5a, 1'b0), 128 * half_ticks + 2, 0, 1);
      run_frame(pack_cmd(1'b1, 2'd2, 5'h1f, 5'h00, 16'hffff, 1'b1), 128 * half_ticks + 2, 0, 0);

      random_start = beats_sent;
      // widest divider: one full half period, then a frame left running into the next phase
      configure(1'($urandom_range(0, 1)), 8'hff, 1'b1);
      repeat (270) send_beat(OP_TICK, tick_payload(1'($urandom_range(0, 1))));
      cmd    = random_payload();
      cmd[0] = 1'b1;
      run_frame(cmd, 40, 5, 2);

      while (beats_sent - random_start < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (sel < 4)      div = 8'd1;
         else if (sel < 6) div = 8'd0;
         else if (sel < 8) div = 8'd2;
         else              div = 8'($urandom_range(3, 5));
         configure(1'($urandom_range(0, 1)), div, 1'($urandom_range(0, 1)));
         repeat ($urandom_range(2, 4)) begin
            if (beats_sent - random_start >= RANDOM_ITEMS) break;
            repeat ($urandom_range(0, 10))
               send_beat(OP_TICK, tick_payload(1'($urandom_range(0, 1))));
            cmd    = random_payload();
            cmd[0] = ($urandom_range(0, 9) != 0);
            ticks  = 128 * half_ticks + $urandom_range(0, 6);
            // now and then cut the frame short so the next command lands on a busy block
            if ($urandom_range(0, 9) == 0)
               ticks = $urandom_range(1, 128 * half_ticks);
            run_frame(cmd, ticks, $urandom_range(0, 8), 2);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #10ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* mdio_master_controller.f */
hw/rtl/mdio_pkg.sv
hw/rtl/mdio_engine.sv
hw/rtl/mdio_skid.sv
hw/rtl/mdio_master_controller.sv
bench/mdio_frame_checker.sv
bench/testbench.sv
